// ===== design/biou_pkg.sv =====
// Shared widths and the per-stage record for the box IoU pipeline.
// No dependencies; used by every module of box_iou_unit.

package biou_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   // box width/height after subtraction
   localparam int DIFF_BITS  = COORD_BITS + 1;
   // product of two differences
   localparam int AREA_BITS  = 2 * DIFF_BITS;
   // area_a + area_b - overlap, with headroom
   localparam int SUM_BITS   = AREA_BITS + 2;
   // result: fraction plus the integer bit for 1.0
   localparam int RATIO_BITS = FRAC_BITS + 1;

   // Data handed from cell to cell along the divider row
   typedef struct packed {
      logic                 zero;   // result forced to 0
      logic                 sat;    // result forced to 1.0
      logic [AREA_BITS-1:0] rem;    // partial remainder
      logic [AREA_BITS-1:0] div;    // divisor (union area)
      logic [FRAC_BITS-1:0] quo;    // quotient bits so far
   } biou_cell_type;

endpackage

// ===== design/biou_front.sv =====
// Front pipeline of box_iou_unit: edge differences, areas, union, special cases.
// Depends on biou_pkg. Four register stages, one transfer per cycle.

module biou_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [biou_pkg::COORD_BITS-1:0] a_left,
   input  logic signed [biou_pkg::COORD_BITS-1:0] a_top,
   input  logic signed [biou_pkg::COORD_BITS-1:0] a_right,
   input  logic signed [biou_pkg::COORD_BITS-1:0] a_bottom,
   input  logic signed [biou_pkg::COORD_BITS-1:0] b_left,
   input  logic signed [biou_pkg::COORD_BITS-1:0] b_top,
   input  logic signed [biou_pkg::COORD_BITS-1:0] b_right,
   input  logic signed [biou_pkg::COORD_BITS-1:0] b_bottom,
   output logic                                  out_valid,
   output biou_pkg::biou_cell_type               out_data
);
   import biou_pkg::*;

   logic [3:0] valid_ff;

   // stage 1: widths, heights, overlap extents
   logic signed [COORD_BITS-1:0] min_r, max_l, min_b, max_t;
   logic signed [DIFF_BITS-1:0]  wa_ff, ha_ff, wb_ff, hb_ff, iw_ff, ih_ff;

   // stage 2: areas
   logic signed [AREA_BITS-1:0]  area_a_ff, area_b_ff, inter2_ff;
   logic                         zero2_ff;

   // stage 3: union
   logic signed [SUM_BITS-1:0]   uni_ff, inter3_ff;
   logic                         zero3_ff;

   // stage 4 output
   biou_cell_type                out_ff;

   assign min_r = (a_right  < b_right)  ? a_right  : b_right;
   assign max_l = (a_left   > b_left)   ? a_left   : b_left;
   assign min_b = (a_bottom < b_bottom) ? a_bottom : b_bottom;
   assign max_t = (a_top    > b_top)    ? a_top    : b_top;

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      wa_ff <= DIFF_BITS'(a_right)  - DIFF_BITS'(a_left);
      ha_ff <= DIFF_BITS'(a_bottom) - DIFF_BITS'(a_top);
      wb_ff <= DIFF_BITS'(b_right)  - DIFF_BITS'(b_left);
      hb_ff <= DIFF_BITS'(b_bottom) - DIFF_BITS'(b_top);
      iw_ff <= DIFF_BITS'(min_r) - DIFF_BITS'(max_l);
      ih_ff <= DIFF_BITS'(min_b) - DIFF_BITS'(max_t);

      area_a_ff <= wa_ff * ha_ff;
      area_b_ff <= wb_ff * hb_ff;
      inter2_ff <= iw_ff * ih_ff;
      zero2_ff  <= (iw_ff <= 0) || (ih_ff <= 0);

      uni_ff    <= SUM_BITS'(area_a_ff) + SUM_BITS'(area_b_ff) - SUM_BITS'(inter2_ff);
      inter3_ff <= SUM_BITS'(inter2_ff);
      zero3_ff  <= zero2_ff || (area_a_ff <= 0) || (area_b_ff <= 0);

      out_ff.zero <= zero3_ff || (uni_ff <= 0);
      out_ff.sat  <= inter3_ff >= uni_ff;
      out_ff.rem  <= inter3_ff[AREA_BITS-1:0];
      out_ff.div  <= uni_ff[AREA_BITS-1:0];
      out_ff.quo  <= '0;
   end

   assign out_valid = valid_ff[3];
   assign out_data  = out_ff;

endmodule

// ===== design/biou_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per transfer.
// Depends on biou_pkg. Cells are chained, FRAC_BITS of them.

module biou_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  biou_pkg::biou_cell_type in_data,
   output logic                    out_valid,
   output biou_pkg::biou_cell_type out_data
);
   import biou_pkg::*;

   logic                 valid_ff;
   biou_cell_type        data_ff;
   logic [AREA_BITS:0]   shifted;
   logic [AREA_BITS:0]   trial;
   logic                 fits;

   // shift remainder, try subtracting the divisor
   assign shifted = {in_data.rem, 1'b0};
   assign trial   = shifted - {1'b0, in_data.div};
   assign fits    = shifted >= {1'b0, in_data.div};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff.zero <= in_data.zero;
      data_ff.sat  <= in_data.sat;
      data_ff.div  <= in_data.div;
      data_ff.rem  <= fits ? trial[AREA_BITS-1:0] : shifted[AREA_BITS-1:0];
      data_ff.quo  <= {in_data.quo[FRAC_BITS-2:0], fits};
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/box_iou_unit.sv =====
// Top level of box_iou_unit: intersection over union of two boxes, fixed point.
// Depends on biou_pkg, biou_front and biou_div_cell.
//
//  channel   transfer when          ports
//  request   start && !busy         req_a_* / req_b_* corners
//  result    rsp_valid (one cycle)  rsp_overlap_ratio
//
// One box pair is taken every cycle; busy stays low.
// A box pair passes through four front stages, one divider
// cell per quotient bit, then the output register.
// Synchronous reset clears only the valid bits; no state survives an item.
// The receiver cannot stall, so results leave on a fixed schedule.

module box_iou_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_a_left,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_a_top,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_a_right,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_a_bottom,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_b_left,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_b_top,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_b_right,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_b_bottom,
   output logic                                   rsp_valid,
   output logic [biou_pkg::RATIO_BITS-1:0]        rsp_overlap_ratio
);
   import biou_pkg::*;

   logic                  chain_valid [FRAC_BITS+1];
   biou_cell_type         chain_data  [FRAC_BITS+1];
   logic                  rsp_valid_ff;
   logic [RATIO_BITS-1:0] ratio_ff, ratio_in;
   biou_cell_type         last;

   assign busy = 1'b0;

   // front stages
   biou_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .a_left    (req_a_left),
      .a_top     (req_a_top),
      .a_right   (req_a_right),
      .a_bottom  (req_a_bottom),
      .b_left    (req_b_left),
      .b_top     (req_b_top),
      .b_right   (req_b_right),
      .b_bottom  (req_b_bottom),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // divider row, one cell per quotient bit
   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
      biou_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // final selection of zero, 1.0 or quotient
   assign last = chain_data[FRAC_BITS];
   always_comb begin
      if (last.zero) begin
         ratio_in = '0;
      end else if (last.sat) begin
         ratio_in = {1'b1, {FRAC_BITS{1'b0}}};
      end else begin
         ratio_in = {1'b0, last.quo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_valid[FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff <= ratio_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_overlap_ratio = ratio_ff;

endmodule

// ===== bench/biou_checker.sv =====
// Checker for box_iou_unit: watches the request and result channels, predicts each ratio
// and compares it with what the block returns. Depends on biou_pkg only.

module biou_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_a_left,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_a_top,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_a_right,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_a_bottom,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_b_left,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_b_top,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_b_right,
   input  logic signed [biou_pkg::COORD_BITS-1:0] req_b_bottom,
   input  logic                                   rsp_valid,
   input  logic [biou_pkg::RATIO_BITS-1:0]        rsp_overlap_ratio,
   output int                                     fail_count,
   output int                                     ratios_in_flight,
   output int                                     pairs_checked,
   output int                                     zero_ratios,
   output int                                     full_ratios
);
   timeunit 1ns;
   timeprecision 1ps;

   import biou_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [RATIO_BITS-1:0]        ratio_type;

   ratio_type pending_ratios[$];

   // Overlap area over union area, truncated to FRAC_BITS fraction bits.
   // Zero for an empty box, an empty overlap or an empty union; 1.0 when the
   // overlap covers the whole union.
   function automatic ratio_type iou_ratio_of(input coord_type al, at, ar, ab,
                                              input coord_type bl, bt, br, bb);
      longint area_a, area_b, ov_w, ov_h, ov_area, uni_area;
      area_a = (longint'(ar) - longint'(al)) * (longint'(ab) - longint'(at));
      area_b = (longint'(br) - longint'(bl)) * (longint'(bb) - longint'(bt));
      if (area_a <= 0 || area_b <= 0)
         return '0;
      ov_w = longint'(ar < br ? ar : br) - longint'(al > bl ? al : bl);
      ov_h = longint'(ab < bb ? ab : bb) - longint'(at > bt ? at : bt);
      if (ov_w <= 0 || ov_h <= 0)
         return '0;
      ov_area  = ov_w * ov_h;
      uni_area = area_a + area_b - ov_area;
      if (uni_area <= 0)
         return '0;
      if (ov_area >= uni_area)
         return ratio_type'(longint'(1) <<< FRAC_BITS);
      return ratio_type'((ov_area <<< FRAC_BITS) / uni_area);
   endfunction

   // Predict on every request transfer, compare on every result transfer
   always @(posedge clock) begin
      ratio_type want;
      if (!reset) begin
         if (start && !busy) begin
            want = iou_ratio_of(req_a_left, req_a_top, req_a_right, req_a_bottom,
                                req_b_left, req_b_top, req_b_right, req_b_bottom);
            pending_ratios.push_back(want);
         end
         if (rsp_valid) begin
            if (pending_ratios.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual overlap_ratio %0d",
                        $time, rsp_overlap_ratio);
            end else begin
               want = pending_ratios.pop_front();
               pairs_checked++;
               if (want == '0)
                  zero_ratios++;
               else if (want == ratio_type'(longint'(1) <<< FRAC_BITS))
                  full_ratios++;
               if (rsp_overlap_ratio !== want) begin
                  fail_count++;
                  $display("%0t: overlap_ratio mismatch, expected %0d, actual %0d",
                           $time, want, rsp_overlap_ratio);
               end
            end
         end
      end
      ratios_in_flight <= pending_ratios.size();
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the box_iou_unit testbench: clock, reset, box-pair stimulus and the verdict.
// Depends on biou_pkg, box_iou_unit and biou_checker.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import biou_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } corners_type;

   localparam int COORD_MAX     = 2 ** (COORD_BITS - 1) - 1;
   localparam int COORD_MIN     = -(2 ** (COORD_BITS - 1));
   localparam int RANDOM_PAIRS  = 1830;
   localparam int CALM_TAIL     = 150;   // last pairs sent back to back
   localparam int QUIET_LIMIT   = 1000;  // cycles without any transfer
   localparam int SETTLE_CYCLES = 40;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  start        = 1'b0;
   logic                  busy;
   coord_type             req_a_left   = '0;
   coord_type             req_a_top    = '0;
   coord_type             req_a_right  = '0;
   coord_type             req_a_bottom = '0;
   coord_type             req_b_left   = '0;
   coord_type             req_b_top    = '0;
   coord_type             req_b_right  = '0;
   coord_type             req_b_bottom = '0;
   logic                  rsp_valid;
   logic [RATIO_BITS-1:0] rsp_overlap_ratio;

   int fail_count, ratios_in_flight, pairs_checked, zero_ratios, full_ratios;
   int quiet_cycles = 0;
   int pairs_sent   = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   box_iou_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_a_left        (req_a_left),
      .req_a_top         (req_a_top),
      .req_a_right       (req_a_right),
      .req_a_bottom      (req_a_bottom),
      .req_b_left        (req_b_left),
      .req_b_top         (req_b_top),
      .req_b_right       (req_b_right),
      .req_b_bottom      (req_b_bottom),
      .rsp_valid         (rsp_valid),
      .rsp_overlap_ratio (rsp_overlap_ratio)
   );

   biou_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_a_left        (req_a_left),
      .req_a_top         (req_a_top),
      .req_a_right       (req_a_right),
      .req_a_bottom      (req_a_bottom),
      .req_b_left        (req_b_left),
      .req_b_top         (req_b_top),
      .req_b_right       (req_b_right),
      .req_b_bottom      (req_b_bottom),
      .rsp_valid         (rsp_valid),
      .rsp_overlap_ratio (rsp_overlap_ratio),
      .fail_count        (fail_count),
      .ratios_in_flight  (ratios_in_flight),
      .pairs_checked     (pairs_checked),
      .zero_ratios       (zero_ratios),
      .full_ratios       (full_ratios)
   );

   // Watchdog: a stuck busy or a lost result ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // One request transfer; start stays high for a following pair
   task automatic send_pair(input corners_type a, input corners_type b);
      start        <= 1'b1;
      req_a_left   <= a.left;
      req_a_top    <= a.top;
      req_a_right  <= a.right;
      req_a_bottom <= a.bottom;
      req_b_left   <= b.left;
      req_b_top    <= b.top;
      req_b_right  <= b.right;
      req_b_bottom <= b.bottom;
      do @(posedge clock); while (busy);
      pairs_sent++;
   endtask

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold the request side until every predicted ratio has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (ratios_in_flight != 0) @(posedge clock);
   endtask

   function automatic corners_type box_at(input int l, input int t, input int r, input int b);
      return '{coord_type'(l), coord_type'(t), coord_type'(r), coord_type'(b)};
   endfunction

   function automatic coord_type clamp_coord(input int v);
      if (v > COORD_MAX)
         return coord_type'(COORD_MAX);
      if (v < COORD_MIN)
         return coord_type'(COORD_MIN);
      return coord_type'(v);
   endfunction

   // Interval of random length up to scale, anywhere in the coordinate range
   function automatic void pick_span(input int scale, output coord_type lo,
                                     output coord_type hi);
      int base, len;
      len  = int'($urandom_range(1, scale));
      base = int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
      if (base + len > COORD_MAX)
         base = COORD_MAX - len;
      lo = coord_type'(base);
      hi = coord_type'(base + len);
   endfunction

   // Interval placed near another so that the two usually overlap
   function automatic void pick_partner(input int scale, input coord_type near_lo,
                                        output coord_type lo, output coord_type hi);
      lo = clamp_coord(int'(near_lo) + int'($urandom_range(0, 2 * scale)) - scale);
      hi = clamp_coord(int'(lo) + int'($urandom_range(1, scale)));
   endfunction

   // Mostly overlapping pairs at mixed scales, some near-identical ones,
   // some degenerate or inverted boxes and some raw noise
   function automatic void make_random_pair(output corners_type a, output corners_type b);
      int        kind, scale;
      coord_type swap;
      case ($urandom_range(0, 3))
         0:       scale = 8;
         1:       scale = 200;
         2:       scale = 5000;
         default: scale = COORD_MAX - COORD_MIN;
      endcase
      pick_span(scale, a.left, a.right);
      pick_span(scale, a.top, a.bottom);
      pick_partner(scale, a.left, b.left, b.right);
      pick_partner(scale, a.top, b.top, b.bottom);
      kind = $urandom_range(0, 99);
      if (kind >= 55 && kind < 65) begin
         b = a;
         if ($urandom_range(0, 1))
            b.right = clamp_coord(int'(b.right) + int'($urandom_range(0, 2)) - 1);
      end else if (kind >= 65 && kind < 75) begin
         case ($urandom_range(0, 3))
            0: a.right = a.left;
            1: begin
               swap     = b.top;
               b.top    = b.bottom;
               b.bottom = swap;
            end
            2: a = '{a.right, a.bottom, a.left, a.top};
            default: b.bottom = b.top;
         endcase
      end else if (kind >= 75) begin
         a = corners_type'({$urandom(), $urandom()});
         b = corners_type'({$urandom(), $urandom()});
      end
   endfunction

   initial begin
      corners_type a, b;
      int          idle_pct;
      idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs
      send_pair(box_at(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX),
                box_at(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));   // identical, full range
      send_pair(box_at(0, 0, 10, 10), box_at(0, 0, 10, 10));            // identical, small
      send_pair(box_at(0, 0, 100, 100), box_at(25, 25, 75, 75));        // nested, one quarter
      send_pair(box_at(25, 25, 75, 75), box_at(0, 0, 100, 100));        // b contains a
      send_pair(box_at(0, 0, 10, 10), box_at(5, 5, 15, 15));            // partial overlap
      send_pair(box_at(0, 0, 10, 10), box_at(10, 0, 20, 10));           // shared edge only
      send_pair(box_at(0, 0, 10, 10), box_at(10, 10, 20, 20));          // shared corner only
      send_pair(box_at(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN + 1),
                box_at(COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX)); // far apart
      send_pair(box_at(5, 0, 5, 10), box_at(0, 0, 10, 10));             // zero-width box
      send_pair(box_at(0, 0, 10, 10), box_at(0, 4, 10, 4));             // zero-height box
      send_pair(box_at(10, 0, 0, 10), box_at(0, 0, 10, 10));            // negative width
      send_pair(box_at(10, 10, 0, 0), box_at(0, 0, 10, 10));            // inverted, positive area
      send_pair(box_at(10, 10, 0, 0), box_at(10, 10, 0, 0));            // both inverted
      send_pair(box_at(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
                box_at(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_pair(box_at(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN),
                box_at(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_pair(box_at(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX),
                box_at(0, 0, 1, 1));                                    // ratio truncates to 0
      send_pair(box_at(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX),
                box_at(COORD_MIN, COORD_MIN, 0, COORD_MAX));            // about one half
      send_pair(box_at(COORD_MIN, 0, COORD_MAX, 1),
                box_at(0, COORD_MIN, 1, COORD_MAX));                    // thin cross, overlap 1
      send_pair(box_at(-100, -50, 50, 100), box_at(-20, -200, 300, 20)); // mixed signs
      send_pair(box_at(0, 0, 1000, 1000), box_at(0, 0, 1000, 999));     // just below one
      send_pair(box_at(-21846, -21846, 21845, 21845),
                box_at(21845, -21846, -21846, 21845));                  // alternating bits
      drain_results();

      // Random pairs; idle rate changes in stretches, none in the tail
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         if (n % 200 == 0)
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(5, 40));
         if (n == RANDOM_PAIRS / 2)
            drain_results();
         make_random_pair(a, b);
         send_pair(a, b);
         if (n < RANDOM_PAIRS - CALM_TAIL && $urandom_range(1, 100) <= idle_pct)
            idle_for($urandom_range(1, 13));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d box pairs, %0d results checked", pairs_sent, pairs_checked);
      $display("ratios: %0d zero, %0d full overlap, %0d fractional",
               zero_ratios, full_ratios, pairs_checked - zero_ratios - full_ratios);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
